FILE: rtl/spim_pkg.sv
package spim_pkg;

    localparam int IDX_W        = 32;
    localparam int ELEM_W       = 64;
    localparam int NSUB_W       = 4;
    localparam int DIMS_REG_W   = 32;
    localparam int PERM_REG_W   = 24;
    localparam int PERM_FIELD_W = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;
    // reciprocal of a dimension scaled by 2^IDX_W, dimension one needs the extra bit
    localparam int RECIP_W      = IDX_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_SUBSYSTEMS = 2'd0,
        CFG_DIMS_PACKED    = 2'd1,
        CFG_PERM_PACKED    = 2'd2
    } cfg_index_t;

endpackage

FILE: rtl/spim_split.sv
module spim_split
    import spim_pkg::*;
#(
    parameter int MAX_SUBSYSTEMS = 8,
    parameter int DIM_BITS       = 4,
    parameter int POS            = 0
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [IDX_W-1:0]                   in_row_rem,
    input  logic [IDX_W-1:0]                   in_col_rem,
    input  logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] in_row_dig,
    input  logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] in_col_dig,
    input  logic [ELEM_W-1:0]                  in_elem,
    input  logic [DIM_BITS:0]                  dim,
    input  logic [RECIP_W-1:0]                 recip,
    output logic                               out_valid,
    output logic [IDX_W-1:0]                   out_row_rem,
    output logic [IDX_W-1:0]                   out_col_rem,
    output logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] out_row_dig,
    output logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] out_col_dig,
    output logic [ELEM_W-1:0]                  out_elem
);

    localparam int PW = IDX_W + RECIP_W;
    localparam int DV = MAX_SUBSYSTEMS * DIM_BITS;

    logic [PW-1:0]    row_prod;
    logic [PW-1:0]    col_prod;

    logic             a_valid_reg;
    logic [IDX_W-1:0] a_row_v_reg;
    logic [IDX_W-1:0] a_col_v_reg;
    logic [IDX_W-1:0] a_row_q_reg;
    logic [IDX_W-1:0] a_col_q_reg;
    logic [DV-1:0]    a_row_dig_reg;
    logic [DV-1:0]    a_col_dig_reg;
    logic [ELEM_W-1:0] a_elem_reg;

    logic [IDX_W-1:0] row_r;
    logic [IDX_W-1:0] col_r;
    logic             row_fix;
    logic             col_fix;
    logic [IDX_W-1:0] row_q_next;
    logic [IDX_W-1:0] col_q_next;
    logic [DV-1:0]    row_dig_next;
    logic [DV-1:0]    col_dig_next;

    logic             b_valid_reg;
    logic [IDX_W-1:0] b_row_rem_reg;
    logic [IDX_W-1:0] b_col_rem_reg;
    logic [DV-1:0]    b_row_dig_reg;
    logic [DV-1:0]    b_col_dig_reg;
    logic [ELEM_W-1:0] b_elem_reg;

    // quotient estimate, low by at most one
    assign row_prod = PW'(in_row_rem) * PW'(recip);
    assign col_prod = PW'(in_col_rem) * PW'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_row_v_reg   <= in_row_rem;
            a_col_v_reg   <= in_col_rem;
            a_row_q_reg   <= row_prod[IDX_W +: IDX_W];
            a_col_q_reg   <= col_prod[IDX_W +: IDX_W];
            a_row_dig_reg <= in_row_dig;
            a_col_dig_reg <= in_col_dig;
            a_elem_reg    <= in_elem;
            b_row_rem_reg <= row_q_next;
            b_col_rem_reg <= col_q_next;
            b_row_dig_reg <= row_dig_next;
            b_col_dig_reg <= col_dig_next;
            b_elem_reg    <= a_elem_reg;
        end
    end

    always_comb
    begin
        row_r   = a_row_v_reg - IDX_W'(a_row_q_reg * IDX_W'(dim));
        col_r   = a_col_v_reg - IDX_W'(a_col_q_reg * IDX_W'(dim));
        row_fix = row_r >= IDX_W'(dim);
        col_fix = col_r >= IDX_W'(dim);
        row_q_next = row_fix ? a_row_q_reg + IDX_W'(1) : a_row_q_reg;
        col_q_next = col_fix ? a_col_q_reg + IDX_W'(1) : a_col_q_reg;
        if (row_fix)
        begin
            row_r = row_r - IDX_W'(dim);
        end
        if (col_fix)
        begin
            col_r = col_r - IDX_W'(dim);
        end
        row_dig_next = a_row_dig_reg;
        col_dig_next = a_col_dig_reg;
        row_dig_next[POS*DIM_BITS +: DIM_BITS] = row_r[DIM_BITS-1:0];
        col_dig_next[POS*DIM_BITS +: DIM_BITS] = col_r[DIM_BITS-1:0];
    end

    assign out_valid   = b_valid_reg;
    assign out_row_rem = b_row_rem_reg;
    assign out_col_rem = b_col_rem_reg;
    assign out_row_dig = b_row_dig_reg;
    assign out_col_dig = b_col_dig_reg;
    assign out_elem    = b_elem_reg;

endmodule

FILE: rtl/spim_permute.sv
module spim_permute
    import spim_pkg::*;
#(
    parameter int MAX_SUBSYSTEMS = 8,
    parameter int DIM_BITS       = 4
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [IDX_W-1:0]                            in_row_rem,
    input  logic [IDX_W-1:0]                            in_col_rem,
    input  logic [MAX_SUBSYSTEMS*DIM_BITS-1:0]          in_row_dig,
    input  logic [MAX_SUBSYSTEMS*DIM_BITS-1:0]          in_col_dig,
    input  logic [ELEM_W-1:0]                           in_elem,
    input  logic [MAX_SUBSYSTEMS-1:0]                   sel_ok,
    input  logic [MAX_SUBSYSTEMS*$clog2(MAX_SUBSYSTEMS)-1:0] sel_idx,
    output logic                                        out_valid,
    output logic [MAX_SUBSYSTEMS*DIM_BITS-1:0]          out_row_dig,
    output logic [MAX_SUBSYSTEMS*DIM_BITS-1:0]          out_col_dig,
    output logic [ELEM_W-1:0]                           out_elem,
    output logic                                        out_oor
);

    localparam int SW = $clog2(MAX_SUBSYSTEMS);
    localparam int DV = MAX_SUBSYSTEMS * DIM_BITS;

    logic [DV-1:0]     row_next;
    logic [DV-1:0]     col_next;
    logic              valid_reg;
    logic [DV-1:0]     row_reg;
    logic [DV-1:0]     col_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic              oor_reg;

    always_comb
    begin
        logic [SW-1:0] idx;
        for (int k = 0; k < MAX_SUBSYSTEMS; k++)
        begin
            idx = sel_idx[k*SW +: SW];
            if (sel_ok[k])
            begin
                row_next[k*DIM_BITS +: DIM_BITS] = in_row_dig[idx*DIM_BITS +: DIM_BITS];
                col_next[k*DIM_BITS +: DIM_BITS] = in_col_dig[idx*DIM_BITS +: DIM_BITS];
            end
            else
            begin
                row_next[k*DIM_BITS +: DIM_BITS] = '0;
                col_next[k*DIM_BITS +: DIM_BITS] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // a quotient left after all digits means the index reached the dimension product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            elem_reg <= in_elem;
            oor_reg  <= (in_row_rem != '0) || (in_col_rem != '0);
        end
    end

    assign out_valid   = valid_reg;
    assign out_row_dig = row_reg;
    assign out_col_dig = col_reg;
    assign out_elem    = elem_reg;
    assign out_oor     = oor_reg;

endmodule

FILE: rtl/spim_join.sv
module spim_join
    import spim_pkg::*;
#(
    parameter int MAX_SUBSYSTEMS = 8,
    parameter int DIM_BITS       = 4,
    parameter int POS            = 0
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [IDX_W-1:0]                   in_row_acc,
    input  logic [IDX_W-1:0]                   in_col_acc,
    input  logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] in_row_dig,
    input  logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] in_col_dig,
    input  logic [ELEM_W-1:0]                  in_elem,
    input  logic                               in_oor,
    input  logic [DIM_BITS:0]                  pdim,
    output logic                               out_valid,
    output logic [IDX_W-1:0]                   out_row_acc,
    output logic [IDX_W-1:0]                   out_col_acc,
    output logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] out_row_dig,
    output logic [MAX_SUBSYSTEMS*DIM_BITS-1:0] out_col_dig,
    output logic [ELEM_W-1:0]                  out_elem,
    output logic                               out_oor
);

    localparam int DV = MAX_SUBSYSTEMS * DIM_BITS;

    logic [IDX_W-1:0]  row_acc_next;
    logic [IDX_W-1:0]  col_acc_next;
    logic              valid_reg;
    logic [IDX_W-1:0]  row_acc_reg;
    logic [IDX_W-1:0]  col_acc_reg;
    logic [DV-1:0]     row_dig_reg;
    logic [DV-1:0]     col_dig_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic              oor_reg;

    // wraps modulo 2^32
    assign row_acc_next = IDX_W'(in_row_acc * IDX_W'(pdim))
                        + IDX_W'(in_row_dig[POS*DIM_BITS +: DIM_BITS]);
    assign col_acc_next = IDX_W'(in_col_acc * IDX_W'(pdim))
                        + IDX_W'(in_col_dig[POS*DIM_BITS +: DIM_BITS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_acc_reg <= row_acc_next;
            col_acc_reg <= col_acc_next;
            row_dig_reg <= in_row_dig;
            col_dig_reg <= in_col_dig;
            elem_reg    <= in_elem;
            oor_reg     <= in_oor;
        end
    end

    assign out_valid   = valid_reg;
    assign out_row_acc = row_acc_reg;
    assign out_col_acc = col_acc_reg;
    assign out_row_dig = row_dig_reg;
    assign out_col_dig = col_dig_reg;
    assign out_elem    = elem_reg;
    assign out_oor     = oor_reg;

endmodule

FILE: rtl/subsystem_permute_index_map.sv
// throughput: one transaction per cycle when not stalled; each digit takes a multiply stage
// and a correct stage, then one permute stage and one multiply-add stage per digit position
// the whole pipe holds while a result is stalled at the output
// reset: asynchronous active low, clears valid bits and sets subsystems 1, dims 1, perm 0
module subsystem_permute_index_map
    import spim_pkg::*;
#(
    parameter int MAX_SUBSYSTEMS = 8,
    parameter int DIM_BITS       = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [IDX_W-1:0]       row_index,
    input  logic [IDX_W-1:0]       col_index,
    input  logic [ELEM_W-1:0]      element_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [IDX_W-1:0]       out_row,
    output logic [IDX_W-1:0]       out_col,
    output logic [ELEM_W-1:0]      element_out,
    output logic                   out_of_range
);

    localparam int SW  = $clog2(MAX_SUBSYSTEMS);
    localparam int NW  = $clog2(MAX_SUBSYSTEMS + 1);
    localparam int CW  = (NW > NSUB_W) ? NW : NSUB_W;
    localparam int DV  = MAX_SUBSYSTEMS * DIM_BITS;
    localparam int NR  = 2 ** DIM_BITS;
    localparam int DW  = DIM_BITS + 1;

    logic [NSUB_W-1:0]     nsub_reg;
    logic [DIMS_REG_W-1:0] dims_reg;
    logic [PERM_REG_W-1:0] perm_reg;
    logic [CW-1:0]         nsub_ext;
    logic [CW-1:0]         n_use;
    logic                  en;

    logic [RECIP_W-1:0]    recip_tab [NR];
    logic [DW-1:0]         dim_use   [MAX_SUBSYSTEMS];
    logic [RECIP_W-1:0]    recip_use [MAX_SUBSYSTEMS];
    logic [DW-1:0]         pdim      [MAX_SUBSYSTEMS];
    logic [MAX_SUBSYSTEMS-1:0]    sel_ok;
    logic [MAX_SUBSYSTEMS*SW-1:0] sel_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsub_reg <= NSUB_W'(1);
            dims_reg <= DIMS_REG_W'(1);
            perm_reg <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_NUM_SUBSYSTEMS: nsub_reg <= wr_data[NSUB_W-1:0];
                CFG_DIMS_PACKED:    dims_reg <= wr_data[DIMS_REG_W-1:0];
                CFG_PERM_PACKED:    perm_reg <= wr_data[PERM_REG_W-1:0];
                default:            ;
            endcase
        end
    end

    assign nsub_ext = CW'(nsub_reg);
    assign n_use    = (nsub_ext == '0) ? CW'(1) :
                      (nsub_ext > CW'(MAX_SUBSYSTEMS)) ? CW'(MAX_SUBSYSTEMS) : nsub_ext;

    genvar gi;
    generate
        for (gi = 0; gi < NR; gi++)
        begin : g_recip
            localparam logic [RECIP_W-1:0] RV = RECIP_W'((64'd1 << IDX_W) / (gi + 1));
            assign recip_tab[gi] = RV;
        end

        for (gi = 0; gi < MAX_SUBSYSTEMS; gi++)
        begin : g_cfg
            logic [DIM_BITS-1:0]     raw;
            logic [PERM_FIELD_W-1:0] src;
            logic [DIMS_REG_W-1:0]   dsh;
            logic [SW-1:0]           sidx;

            if (gi * DIM_BITS < DIMS_REG_W)
            begin : g_dim_in
                assign dsh = dims_reg >> (gi * DIM_BITS);
            end
            else
            begin : g_dim_out
                assign dsh = '0;
            end
            assign raw = dsh[DIM_BITS-1:0];

            if (gi * PERM_FIELD_W < PERM_REG_W)
            begin : g_perm_in
                assign src = perm_reg[gi*PERM_FIELD_W +: PERM_FIELD_W];
            end
            else
            begin : g_perm_out
                assign src = '0;
            end

            // positions past the subsystem count act as dimension one
            assign dim_use[gi]   = (CW'(gi) < n_use) ? DW'(raw) + DW'(1) : DW'(1);
            assign recip_use[gi] = recip_tab[DIM_BITS'(dim_use[gi] - DW'(1))];
            assign sidx          = SW'(src);
            assign sel_ok[gi]    = (CW'(gi) < n_use) && (CW'(src) < n_use);
            assign sel_idx[gi*SW +: SW] = sidx;
            assign pdim[gi]      = sel_ok[gi] ? dim_use[sidx] : DW'(1);
        end
    endgenerate

    assign en       = !(out_valid && out_stall);
    assign in_stall = out_valid && out_stall;

    // split chain, least significant subsystem first
    logic              sp_valid [MAX_SUBSYSTEMS+1];
    logic [IDX_W-1:0]  sp_row   [MAX_SUBSYSTEMS+1];
    logic [IDX_W-1:0]  sp_col   [MAX_SUBSYSTEMS+1];
    logic [DV-1:0]     sp_rdig  [MAX_SUBSYSTEMS+1];
    logic [DV-1:0]     sp_cdig  [MAX_SUBSYSTEMS+1];
    logic [ELEM_W-1:0] sp_elem  [MAX_SUBSYSTEMS+1];

    assign sp_valid[0] = in_valid;
    assign sp_row[0]   = row_index;
    assign sp_col[0]   = col_index;
    assign sp_rdig[0]  = '0;
    assign sp_cdig[0]  = '0;
    assign sp_elem[0]  = element_in;

    generate
        for (gi = 0; gi < MAX_SUBSYSTEMS; gi++)
        begin : g_split
            spim_split #(
                .MAX_SUBSYSTEMS (MAX_SUBSYSTEMS),
                .DIM_BITS       (DIM_BITS),
                .POS            (MAX_SUBSYSTEMS - 1 - gi)
            ) u_split (
                .clk         (clk),
                .rst_n       (rst_n),
                .en          (en),
                .in_valid    (sp_valid[gi]),
                .in_row_rem  (sp_row[gi]),
                .in_col_rem  (sp_col[gi]),
                .in_row_dig  (sp_rdig[gi]),
                .in_col_dig  (sp_cdig[gi]),
                .in_elem     (sp_elem[gi]),
                .dim         (dim_use[MAX_SUBSYSTEMS-1-gi]),
                .recip       (recip_use[MAX_SUBSYSTEMS-1-gi]),
                .out_valid   (sp_valid[gi+1]),
                .out_row_rem (sp_row[gi+1]),
                .out_col_rem (sp_col[gi+1]),
                .out_row_dig (sp_rdig[gi+1]),
                .out_col_dig (sp_cdig[gi+1]),
                .out_elem    (sp_elem[gi+1])
            );
        end
    endgenerate

    logic              jn_valid [MAX_SUBSYSTEMS+1];
    logic [IDX_W-1:0]  jn_row   [MAX_SUBSYSTEMS+1];
    logic [IDX_W-1:0]  jn_col   [MAX_SUBSYSTEMS+1];
    logic [DV-1:0]     jn_rdig  [MAX_SUBSYSTEMS+1];
    logic [DV-1:0]     jn_cdig  [MAX_SUBSYSTEMS+1];
    logic [ELEM_W-1:0] jn_elem  [MAX_SUBSYSTEMS+1];
    logic              jn_oor   [MAX_SUBSYSTEMS+1];

    spim_permute #(
        .MAX_SUBSYSTEMS (MAX_SUBSYSTEMS),
        .DIM_BITS       (DIM_BITS)
    ) u_permute (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (sp_valid[MAX_SUBSYSTEMS]),
        .in_row_rem  (sp_row[MAX_SUBSYSTEMS]),
        .in_col_rem  (sp_col[MAX_SUBSYSTEMS]),
        .in_row_dig  (sp_rdig[MAX_SUBSYSTEMS]),
        .in_col_dig  (sp_cdig[MAX_SUBSYSTEMS]),
        .in_elem     (sp_elem[MAX_SUBSYSTEMS]),
        .sel_ok      (sel_ok),
        .sel_idx     (sel_idx),
        .out_valid   (jn_valid[0]),
        .out_row_dig (jn_rdig[0]),
        .out_col_dig (jn_cdig[0]),
        .out_elem    (jn_elem[0]),
        .out_oor     (jn_oor[0])
    );

    assign jn_row[0] = '0;
    assign jn_col[0] = '0;

    // recombine, most significant position first
    generate
        for (gi = 0; gi < MAX_SUBSYSTEMS; gi++)
        begin : g_join
            spim_join #(
                .MAX_SUBSYSTEMS (MAX_SUBSYSTEMS),
                .DIM_BITS       (DIM_BITS),
                .POS            (gi)
            ) u_join (
                .clk         (clk),
                .rst_n       (rst_n),
                .en          (en),
                .in_valid    (jn_valid[gi]),
                .in_row_acc  (jn_row[gi]),
                .in_col_acc  (jn_col[gi]),
                .in_row_dig  (jn_rdig[gi]),
                .in_col_dig  (jn_cdig[gi]),
                .in_elem     (jn_elem[gi]),
                .in_oor      (jn_oor[gi]),
                .pdim        (pdim[gi]),
                .out_valid   (jn_valid[gi+1]),
                .out_row_acc (jn_row[gi+1]),
                .out_col_acc (jn_col[gi+1]),
                .out_row_dig (jn_rdig[gi+1]),
                .out_col_dig (jn_cdig[gi+1]),
                .out_elem    (jn_elem[gi+1]),
                .out_oor     (jn_oor[gi+1])
            );
        end
    endgenerate

    assign out_valid    = jn_valid[MAX_SUBSYSTEMS];
    assign out_of_range = jn_oor[MAX_SUBSYSTEMS];
    assign out_row      = jn_oor[MAX_SUBSYSTEMS] ? '0 : jn_row[MAX_SUBSYSTEMS];
    assign out_col      = jn_oor[MAX_SUBSYSTEMS] ? '0 : jn_col[MAX_SUBSYSTEMS];
    assign element_out  = jn_elem[MAX_SUBSYSTEMS];

endmodule
